FILE: design/ade_pkg.sv
`timescale 1ns / 1ps

package ade_pkg;

    // Opcodes on the input channel
    localparam logic [2:0] OP_INS_LEFT  = 3'd0;
    localparam logic [2:0] OP_INS_RIGHT = 3'd1;
    localparam logic [2:0] OP_DEL_LEFT  = 3'd2;
    localparam logic [2:0] OP_DEL_RIGHT = 3'd3;
    localparam logic [2:0] OP_DISPLAY   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               last;
    } out_item_t;

    typedef enum logic [2:0] {
        CMD_INS_LEFT,
        CMD_INS_RIGHT,
        CMD_DEL_LEFT,
        CMD_DEL_RIGHT,
        CMD_DISPLAY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic signed [31:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_OUT
    } bk_state_t;

endpackage

FILE: design/ade_front.sv
`timescale 1ns / 1ps

module ade_front (
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ade_pkg::in_item_t s_data,
    input  logic             cmdq_full,
    output logic             cmd_push,
    output ade_pkg::cmd_t    cmd_wdata
);

    logic legal_op;

    // Take a transaction whenever the queue has room
    assign s_ready = ~cmdq_full;

    // Classify the opcode; drop codes that mean nothing
    always_comb begin
        legal_op       = 1'b1;
        cmd_wdata.kind = ade_pkg::CMD_DISPLAY;
        unique case (s_data.opcode)
            ade_pkg::OP_INS_LEFT:  cmd_wdata.kind = ade_pkg::CMD_INS_LEFT;
            ade_pkg::OP_INS_RIGHT: cmd_wdata.kind = ade_pkg::CMD_INS_RIGHT;
            ade_pkg::OP_DEL_LEFT:  cmd_wdata.kind = ade_pkg::CMD_DEL_LEFT;
            ade_pkg::OP_DEL_RIGHT: cmd_wdata.kind = ade_pkg::CMD_DEL_RIGHT;
            ade_pkg::OP_DISPLAY:   cmd_wdata.kind = ade_pkg::CMD_DISPLAY;
            default:               legal_op       = 1'b0;
        endcase
        cmd_wdata.value = s_data.value;
    end

    assign cmd_push = s_valid & s_ready & legal_op & aresetn;

endmodule

FILE: design/ade_cmd_fifo.sv
`timescale 1ns / 1ps

module ade_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ade_pkg::cmd_t wdata,
    output logic          full,
    input  logic          pop,
    output logic          rvalid,
    output ade_pkg::cmd_t rdata
);

    localparam int PTR_W = $clog2(ade_pkg::CMDQ_DEPTH);
    localparam int CNT_W = $clog2(ade_pkg::CMDQ_DEPTH + 1);

    ade_pkg::cmd_t    entry_reg [ade_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == CNT_W'(ade_pkg::CMDQ_DEPTH));
    assign rvalid = (count_reg != '0);
    assign rdata  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ade_pkg::CMDQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ade_pkg::CMDQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: design/ade_back.sv
`timescale 1ns / 1ps

module ade_back #(
    parameter int DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    input  ade_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output ade_pkg::out_item_t m_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);

    ade_pkg::bk_state_t state_reg, state_next;

    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic               empty_reg, empty_next;
    logic [IDX_W-1:0]   cursor_reg, cursor_next;
    logic               disp_reg, disp_next;
    ade_pkg::out_item_t out_reg, out_next;
    logic               load_out;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic               wr_en, rd_en;
    logic [IDX_W-1:0]   wr_addr, rd_addr;
    logic               needs_read;
    logic               more_disp;

    // Deletes and displays of a non-empty queue go through the slot memory
    assign needs_read = !empty_reg &&
                        (cmd.kind == ade_pkg::CMD_DEL_LEFT ||
                         cmd.kind == ade_pkg::CMD_DEL_RIGHT ||
                         cmd.kind == ade_pkg::CMD_DISPLAY);
    assign more_disp  = disp_reg && !out_reg.last;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ade_pkg::BK_IDLE: begin
                if (cmd_valid) begin
                    state_next = needs_read ? ade_pkg::BK_READ : ade_pkg::BK_OUT;
                end
            end
            ade_pkg::BK_READ: begin
                state_next = ade_pkg::BK_OUT;
            end
            ade_pkg::BK_OUT: begin
                if (m_ready) begin
                    state_next = more_disp ? ade_pkg::BK_READ : ade_pkg::BK_IDLE;
                end
            end
            default: state_next = ade_pkg::BK_IDLE;
        endcase
    end

    // Datapath control and index updates
    always_comb begin
        cmd_pop     = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        rd_en       = 1'b0;
        rd_addr     = cursor_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        cursor_next = cursor_reg;
        disp_next   = disp_reg;
        load_out    = 1'b0;
        out_next    = '{status: ade_pkg::ST_OK, data: '0, last: 1'b1};
        unique case (state_reg)
            ade_pkg::BK_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        ade_pkg::CMD_INS_LEFT: begin
                            load_out = 1'b1;
                            if (empty_reg) begin
                                wr_en      = 1'b1;
                                head_next  = '0;
                                tail_next  = '0;
                                empty_next = 1'b0;
                            end else if (head_reg == '0) begin
                                out_next.status = ade_pkg::ST_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                wr_addr   = head_reg - IDX_W'(1);
                                head_next = head_reg - IDX_W'(1);
                            end
                        end
                        ade_pkg::CMD_INS_RIGHT: begin
                            load_out = 1'b1;
                            if (empty_reg) begin
                                wr_en      = 1'b1;
                                head_next  = '0;
                                tail_next  = '0;
                                empty_next = 1'b0;
                            end else if (tail_reg == LAST_SLOT) begin
                                out_next.status = ade_pkg::ST_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                wr_addr   = tail_reg + IDX_W'(1);
                                tail_next = tail_reg + IDX_W'(1);
                            end
                        end
                        ade_pkg::CMD_DEL_LEFT,
                        ade_pkg::CMD_DEL_RIGHT: begin
                            disp_next = 1'b0;
                            if (empty_reg) begin
                                load_out        = 1'b1;
                                out_next.status = ade_pkg::ST_EMPTY;
                            end else begin
                                rd_en = 1'b1;
                                if (cmd.kind == ade_pkg::CMD_DEL_LEFT) begin
                                    rd_addr = head_reg;
                                end else begin
                                    rd_addr = tail_reg;
                                end
                                if (head_reg == tail_reg) begin
                                    head_next  = '0;
                                    tail_next  = '0;
                                    empty_next = 1'b1;
                                end else if (cmd.kind == ade_pkg::CMD_DEL_LEFT) begin
                                    head_next = head_reg + IDX_W'(1);
                                end else begin
                                    tail_next = tail_reg - IDX_W'(1);
                                end
                            end
                        end
                        ade_pkg::CMD_DISPLAY: begin
                            if (empty_reg) begin
                                disp_next       = 1'b0;
                                load_out        = 1'b1;
                                out_next.status = ade_pkg::ST_EMPTY;
                            end else begin
                                disp_next   = 1'b1;
                                rd_en       = 1'b1;
                                rd_addr     = head_reg;
                                cursor_next = head_reg;
                            end
                        end
                        default: begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            ade_pkg::BK_READ: begin
                load_out      = 1'b1;
                out_next.data = rd_data_reg;
                out_next.last = !disp_reg || (cursor_reg == tail_reg);
            end
            ade_pkg::BK_OUT: begin
                // Step the display cursor once the current result is taken
                if (m_ready && more_disp) begin
                    cursor_next = cursor_reg + IDX_W'(1);
                    rd_en       = 1'b1;
                    rd_addr     = cursor_reg + IDX_W'(1);
                end
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ade_pkg::BK_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            empty_reg  <= 1'b1;
            cursor_reg <= '0;
            disp_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            empty_reg  <= empty_next;
            cursor_reg <= cursor_next;
            disp_reg   <= disp_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= out_next;
        end
    end

    // Slot memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= cmd.value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_valid = (state_reg == ade_pkg::BK_OUT);
    assign m_data  = out_reg;

endmodule

FILE: design/array_deque_engine.sv
`timescale 1ns / 1ps
// An insert result passes through the command queue and the result register; a delete
// also goes through the registered slot read. The back-end sequencer takes a new command only
// once the last result is taken; a display reads each stored element in turn, head to tail.
// Unknown opcodes are taken and dropped without a result.
// Reset (aresetn low, synchronous) empties the queue and clears the command queue;
// slot contents are kept and need no clearing pass.
module array_deque_engine #(
    parameter int DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ade_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ade_pkg::out_item_t m_data
);

    logic          cmdq_full;
    logic          cmd_push;
    ade_pkg::cmd_t cmd_wdata;
    logic          cmd_valid;
    logic          cmd_pop;
    ade_pkg::cmd_t cmd_rdata;

    ade_front u_front (
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmdq_full (cmdq_full),
        .cmd_push  (cmd_push),
        .cmd_wdata (cmd_wdata)
    );

    ade_cmd_fifo u_cmdq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (cmd_push),
        .wdata   (cmd_wdata),
        .full    (cmdq_full),
        .pop     (cmd_pop),
        .rvalid  (cmd_valid),
        .rdata   (cmd_rdata)
    );

    ade_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_rdata),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Back end never takes a command the queue does not hold
    a_pop_needs_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    // Every legal transaction reaches the command queue
    a_legal_pushed: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.opcode <= ade_pkg::OP_DISPLAY) |-> cmd_push)
        else $error("legal transaction not queued");

    // Unknown opcodes are dropped
    a_illegal_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.opcode > ade_pkg::OP_DISPLAY) |-> !cmd_push)
        else $error("unknown opcode queued");

    // No result appears in the cycle after reset
    a_quiet_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule
